FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define OND_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// Condition that must never hold outside reset
`define OND_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) else $error(msg);

`endif

FILE: sv/ond_pkg.sv
// Types and constants for the octahedral normal decoder
`default_nettype none
package ond_pkg;

  localparam int FULL_SCALE = 32767;
  localparam int MW    = 15;   // component magnitude
  localparam int QW    = 15;   // quotient bits, one per cell
  localparam int PW    = 30;   // product of two magnitudes
  localparam int SW    = 32;   // squared length
  localparam int TW    = 62;   // 4 * (K*m)^2
  localparam int AW    = 68;   // running products in the cells
  localparam int NCELL = QW;
  localparam int BW    = 4;    // bit index

  typedef struct packed {
    logic signed [15:0] enc_x;
    logic signed [15:0] enc_y;
  } item_t;

  typedef struct packed {
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
  } result_t;

  typedef struct packed {
    logic                   valid;
    logic [2:0][MW-1:0]     mag;
    logic [2:0]             neg;
  } f1_t;

  typedef struct packed {
    logic                   valid;
    logic [2:0][PW-1:0]     sq;
    logic [2:0][PW-1:0]     km;
    logic [2:0]             neg;
  } f2_t;

  typedef struct packed {
    logic                   valid;
    logic [SW-1:0]          s;
    logic [2:0][TW-1:0]     t;
    logic [2:0]             neg;
  } front_t;

  typedef struct packed {
    logic signed [AW-1:0]   a;    // d^2 * s for the accepted prefix
    logic signed [AW-1:0]   b;    // d * s
    logic [TW-1:0]          t;
    logic [QW-1:0]          q;
    logic                   neg;
  } lane_t;

  typedef struct packed {
    logic                   valid;
    logic [SW-1:0]          s;
    lane_t [2:0]            lane;
  } cell_t;

endpackage
`default_nettype wire

FILE: sv/ond_front.sv
// Clamp, fold, squares and target products ahead of the cell chain
`default_nettype none
module ond_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            valid,
  input  wire ond_pkg::item_t  item,
  output ond_pkg::front_t      dout
);

  ond_pkg::f1_t f1, f1_next;
  ond_pkg::f2_t f2, f2_next;
  ond_pkg::front_t f3_next;

  logic [ond_pkg::MW-1:0] mx, my;
  logic                   sx, sy;
  logic [ond_pkg::MW:0]   sum;
  logic                   fold;
  localparam logic [ond_pkg::MW:0] K16 = (ond_pkg::MW+1)'(ond_pkg::FULL_SCALE);

  always_comb begin
    // -32768 clamps to -32767, whose magnitude is the same as 32767
    sx = item.enc_x[15];
    sy = item.enc_y[15];
    mx = (item.enc_x == 16'sh8000) ? ond_pkg::MW'(ond_pkg::FULL_SCALE)
                                   : ond_pkg::MW'(sx ? -item.enc_x : item.enc_x);
    my = (item.enc_y == 16'sh8000) ? ond_pkg::MW'(ond_pkg::FULL_SCALE)
                                   : ond_pkg::MW'(sy ? -item.enc_y : item.enc_y);
    sum  = {1'b0, mx} + {1'b0, my};
    fold = sum > K16;
    f1_next.valid = valid;
    f1_next.neg   = {fold, sy, sx};
    f1_next.mag[2] = fold ? ond_pkg::MW'(sum - K16) : ond_pkg::MW'(K16 - sum);
    f1_next.mag[0] = fold ? ond_pkg::MW'(K16 - {1'b0, my}) : mx;
    f1_next.mag[1] = fold ? ond_pkg::MW'(K16 - {1'b0, mx}) : my;
  end

  always_comb begin
    f2_next.valid = f1.valid;
    f2_next.neg   = f1.neg;
    for (int i = 0; i < 3; i++) begin
      f2_next.sq[i] = {{(ond_pkg::PW-ond_pkg::MW){1'b0}}, f1.mag[i]}
                    * {{(ond_pkg::PW-ond_pkg::MW){1'b0}}, f1.mag[i]};
      f2_next.km[i] = {{(ond_pkg::PW-ond_pkg::MW){1'b0}}, f1.mag[i]}
                    * ond_pkg::PW'(ond_pkg::FULL_SCALE);
    end
  end

  always_comb begin
    f3_next.valid = f2.valid;
    f3_next.neg   = f2.neg;
    f3_next.s     = ond_pkg::SW'(f2.sq[0]) + ond_pkg::SW'(f2.sq[1]) + ond_pkg::SW'(f2.sq[2]);
    for (int i = 0; i < 3; i++) begin
      f3_next.t[i] = ({{(ond_pkg::TW-ond_pkg::PW){1'b0}}, f2.km[i]}
                   * {{(ond_pkg::TW-ond_pkg::PW){1'b0}}, f2.km[i]}) << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1   <= '0;
      f2   <= '0;
      dout <= '0;
    end else if (en) begin
      f1   <= f1_next;
      f2   <= f2_next;
      dout <= f3_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ond_cell.sv
// One quotient bit of the rounded normalisation, for all three components
`default_nettype none
module ond_cell (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic [ond_pkg::BW-1:0] bit_idx,
  input  wire ond_pkg::cell_t         din,
  output ond_pkg::cell_t              dout
);

  ond_pkg::cell_t dout_next;
  logic signed [ond_pkg::AW-1:0] sx;
  logic signed [ond_pkg::AW-1:0] cand [3];
  logic [5:0] sh_b1, sh_b2, sh_s;

  // candidate d = D + 2^(b+1): d^2 s = D^2 s + D s 2^(b+2) + s 2^(2b+2)
  always_comb begin
    sx    = $signed({{(ond_pkg::AW-ond_pkg::SW){1'b0}}, din.s});
    sh_b1 = {2'b00, bit_idx} + 6'd1;
    sh_b2 = {2'b00, bit_idx} + 6'd2;
    sh_s  = {1'b0, bit_idx, 1'b0} + 6'd2;
    dout_next = din;
    for (int i = 0; i < 3; i++) begin
      cand[i] = din.lane[i].a + (din.lane[i].b <<< sh_b2) + (sx <<< sh_s);
      if (cand[i] <= $signed({{(ond_pkg::AW-ond_pkg::TW){1'b0}}, din.lane[i].t})) begin
        dout_next.lane[i].a = cand[i];
        dout_next.lane[i].b = din.lane[i].b + (sx <<< sh_b1);
        dout_next.lane[i].q = din.lane[i].q | (ond_pkg::QW'(1) << bit_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/octahedral_normal_decode.sv
// Octahedral normal decoder top level: front end, bit cell chain, result register
//
//  channel  | valid        | stall        | payload
//  item     | item_valid   | item_stall   | item   (enc_x, enc_y)
//  result   | result_valid | result_stall | result (norm_x, norm_y, norm_z)
//
// One item per cycle while not stalled; 3 front stages, 15 bit cells, then the result reg.
// The whole pipe advances together; it holds while a result waits under stall.
// item_stall is high only while the result register is full and stalled.
// rst is synchronous and empties every stage.
`default_nettype none
`include "assert_macros.svh"
module octahedral_normal_decode (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire ond_pkg::item_t    item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output ond_pkg::result_t       result
);

  logic en;
  ond_pkg::front_t front;
  ond_pkg::cell_t  chain [ond_pkg::NCELL+1];
  logic [ond_pkg::NCELL:0] chain_v;
  ond_pkg::cell_t  last;
  logic [2:0][15:0] comp;

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  ond_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .valid (item_valid),
    .item  (item),
    .dout  (front)
  );

  // start with D = -1: a = s, b = -s
  always_comb begin
    chain[0].valid = front.valid;
    chain[0].s     = front.s;
    for (int i = 0; i < 3; i++) begin
      chain[0].lane[i].a   = $signed({{(ond_pkg::AW-ond_pkg::SW){1'b0}}, front.s});
      chain[0].lane[i].b   = -$signed({{(ond_pkg::AW-ond_pkg::SW){1'b0}}, front.s});
      chain[0].lane[i].t   = front.t[i];
      chain[0].lane[i].q   = '0;
      chain[0].lane[i].neg = front.neg[i];
    end
  end

  for (genvar g = 0; g < ond_pkg::NCELL; g++) begin : g_cell
    ond_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .bit_idx (ond_pkg::BW'(ond_pkg::QW - 1 - g)),
      .din     (chain[g]),
      .dout    (chain[g+1])
    );
  end

  for (genvar g = 0; g <= ond_pkg::NCELL; g++) begin : g_v
    assign chain_v[g] = chain[g].valid;
  end

  assign last = chain[ond_pkg::NCELL];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      comp[i] = last.lane[i].neg ? -{1'b0, last.lane[i].q} : {1'b0, last.lane[i].q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.norm_x <= comp[0];
      result.norm_y <= comp[1];
      result.norm_z <= comp[2];
    end
  end

  `OND_ASSERT(a_hold_chain, clk, rst, (result_valid && result_stall) |=> $stable(chain_v), "chain moved under stall")
  `OND_ASSERT(a_stall_cause, clk, rst, item_stall |-> result_valid, "input stalled with empty result register")
  `OND_NEVER(a_range, clk, rst, result_valid && (result.norm_x == 16'sh8000 || result.norm_y == 16'sh8000 || result.norm_z == 16'sh8000), "result out of range")

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Testbench for the octahedral normal decoder: queued driver, monitor and integer predictor
`timescale 1ns / 1ps
module tb;

  localparam int FS = 32767;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  ond_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  ond_pkg::result_t result;

  ond_pkg::item_t pending_items[$];
  ond_pkg::result_t expected_normals[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #10 clk = ~clk;

  octahedral_normal_decode u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  // nearest integer to FS*|c|/sqrt(s), bitwise search on (2q-1)^2 * s <= 4*FS^2*c^2
  function automatic logic signed [15:0] scale_comp(int c, longint unsigned s);
    longint unsigned m, lim, cand, d;
    logic [14:0] q;
    m = (c < 0) ? -c : c;
    lim = 4 * longint'(FS) * longint'(FS) * m * m;
    q = '0;
    for (int b = 14; b >= 0; b--) begin
      cand = q | (15'd1 << b);
      d = 2 * cand - 1;
      if (d * d * s <= lim) q = cand[14:0];
    end
    return (c < 0) ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic ond_pkg::result_t decode_normal(ond_pkg::item_t it);
    int x, y, z, ox;
    longint unsigned s;
    ond_pkg::result_t r;
    x = (it.enc_x < -FS) ? -FS : int'(it.enc_x);
    y = (it.enc_y < -FS) ? -FS : int'(it.enc_y);
    z = FS - (x < 0 ? -x : x) - (y < 0 ? -y : y);
    if (z < 0) begin
      // lower hemisphere fold, zero counts as positive
      ox = x;
      x = (FS - (y < 0 ? -y : y)) * (ox >= 0 ? 1 : -1);
      y = (FS - (ox < 0 ? -ox : ox)) * (y >= 0 ? 1 : -1);
    end
    s = longint'(x) * x + longint'(y) * y + longint'(z) * z;
    r.norm_x = scale_comp(x, s);
    r.norm_y = scale_comp(y, s);
    r.norm_z = scale_comp(z, s);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, checked);
    errors++;
  endtask

  task automatic add_item(logic [15:0] ex, logic [15:0] ey);
    ond_pkg::item_t it;
    it.enc_x = ex;
    it.enc_y = ey;
    pending_items = {pending_items, it};
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_normals = {expected_normals, decode_normal(item)};
        accepted++;
      end
      if (!item_valid || !item_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_normals.size() == 0) begin
          $display("unexpected transfer on result channel");
          errors++;
        end else begin
          ond_pkg::result_t w;
          w = expected_normals.pop_front();
          if (result.norm_x !== w.norm_x) report_mismatch("norm_x", result.norm_x, w.norm_x);
          if (result.norm_y !== w.norm_y) report_mismatch("norm_y", result.norm_y, w.norm_y);
          if (result.norm_z !== w.norm_z) report_mismatch("norm_z", result.norm_z, w.norm_z);
          checked++;
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d outstanding", cycles, expected_normals.size());
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    logic [15:0] edges[6];
    edges = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, clamp, fold at each sign, zero components
    foreach (edges[i])
      foreach (edges[j])
        if (i < 5 || j < 5) add_item(edges[i], edges[j]);
    add_item(16'h4000, 16'h3FFF);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        default: begin send_idle_pct = 48; recv_stall_pct = 48; end
      endcase
      for (int k = 0; k < 360; k++) begin
        case ($urandom_range(3))
          0: add_item($urandom, $urandom);
          1: add_item($urandom_range(32767), $urandom_range(32767) | 16'h8000);
          // near the fold boundary |x|+|y| = 32767
          2: begin
            int a;
            a = $urandom_range(32767);
            add_item(($urandom_range(1) ? a : -a), ($urandom_range(1) ? 1 : -1)
                     * (32767 - a + int'($urandom_range(2)) - 1));
          end
          default: add_item($urandom_range(3) - 1, $urandom);
        endcase
      end
      wait (pending_items.size() == 0);
      @(posedge clk);
      while (item_valid) @(posedge clk);
      wait (expected_normals.size() == 0);
    end
    recv_stall_pct = 0;
    repeat (40) @(posedge clk);
    $display("sent %0d items, decoded %0d normals over five idling phases", accepted, checked);
    $display("covered clamp, fold, zero and boundary inputs");
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/ond_pkg.sv
sv/ond_front.sv
sv/ond_cell.sv
sv/octahedral_normal_decode.sv
bench/tb.sv
